[design/trfis_pkg.sv]
// types and constants shared by the interval table search block
// no dependencies; compile first

package trfis_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 10;

    // operation codes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_BAD     = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_NOCOVER = 3'd3,
        STS_FULL    = 3'd4
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_F_FIRST,
        S_F_PROBE,
        S_F_TAIL,
        S_C_LAST,
        S_C_PROBE,
        S_C_TAIL,
        S_CHECK,
        S_DONE
    } t_state;

    // table read address source
    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_MID,
        ADDR_LO
    } t_addr_sel;

    // search bound update
    typedef enum logic [1:0] {
        BND_HOLD,
        BND_INIT,
        BND_STEP
    } t_bnd_op;

    // search result source
    typedef enum logic [2:0] {
        RES_NEG1,
        RES_LAST,
        RES_MID,
        RES_LO,
        RES_LOM1,
        RES_LOP1
    } t_res_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic      in_ready;
        logic      wr_en;
        logic      cnt_inc;
        logic      cnt_clr;
        logic      ceil_sel;
        t_addr_sel addr_sel;
        t_bnd_op   bnd_op;
        t_res_sel  res_sel;
        logic      res_wr_a;
        logic      res_wr_b;
        logic      set_status;
        t_status   status;
        logic      idx_en;
        logic      load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            bad_append;
        logic            bad_query;
        logic            full;
        logic            empty;
        logic            key_lt;
        logic            key_gt;
        logic            more;
        logic            lo_in;
        logic            cover_ok;
        logic            out_free;
    } t_dp_stat;

endpackage

[design/trfis_in_if.sv]
// request channel: valid/ready handshake with operation and two timestamps
// depends on trfis_pkg

interface trfis_in_if;
    logic                         valid;
    logic                         ready;
    logic [trfis_pkg::OP_W-1:0]   op;
    logic [trfis_pkg::TIME_W-1:0] start_ts;
    logic [trfis_pkg::TIME_W-1:0] stop_time;

    modport source (output valid, output op, output start_ts, output stop_time,
                    input ready);
    modport sink (input valid, input op, input start_ts, input stop_time,
                  output ready);
endinterface

[design/trfis_out_if.sv]
// response channel: valid/ready handshake with status and index range
// depends on trfis_pkg

interface trfis_out_if;
    logic                           valid;
    logic                           ready;
    logic [trfis_pkg::STATUS_W-1:0] status;
    logic [trfis_pkg::INDEX_W-1:0]  first_index;
    logic [trfis_pkg::INDEX_W-1:0]  last_index;

    modport source (output valid, output status, output first_index,
                    output last_index, input ready);
    modport sink (input valid, input status, input first_index,
                  input last_index, output ready);
endinterface

[design/trfis_ram.sv]
// generic single-port ram with registered read data
// no dependencies

module trfis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/trfis_dp.sv]
// datapath: request latch, entry count, interval table, search bounds, result
// depends on trfis_pkg, trfis_in_if, trfis_out_if, trfis_ram

module trfis_dp #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    trfis_in_if.sink            i_req,
    trfis_out_if.source         o_rsp,
    input  trfis_pkg::t_dp_cmd  i_cmd,
    output trfis_pkg::t_dp_stat o_stat
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = CW + 1;
    localparam int TW = trfis_pkg::TIME_W;
    localparam int XW = trfis_pkg::INDEX_W;
    localparam logic signed [LW-1:0] ONE = LW'(1);

    logic [trfis_pkg::OP_W-1:0] r_op;
    logic [TW-1:0]              r_t0;
    logic [TW-1:0]              r_t1;
    logic [CW-1:0]              r_count;
    logic signed [LW-1:0]       r_lo, n_lo;
    logic signed [LW-1:0]       r_hi, n_hi;
    logic signed [LW-1:0]       r_mid;
    logic signed [LW-1:0]       r_a;
    logic signed [LW-1:0]       r_b;
    logic [trfis_pkg::STATUS_W-1:0] r_status;
    logic [XW-1:0]              r_first;
    logic [XW-1:0]              r_last;
    logic                       r_out_valid;
    logic [trfis_pkg::STATUS_W-1:0] r_out_status;
    logic [XW-1:0]              r_out_first;
    logic [XW-1:0]              r_out_last;

    logic signed [LW-1:0] n_sgn;
    logic signed [LW-1:0] n_m1;
    logic [LW-1:0]        mid_sum;
    logic signed [LW-1:0] mid_calc;
    logic signed [LW-1:0] res_val;
    logic [IW-1:0]        ram_addr;
    logic [2*TW-1:0]      ram_rdata;
    logic [TW-1:0]        key;
    logic [TW-1:0]        probe;
    logic                 accept;

    // no request is taken while reset is held
    assign i_req.ready = i_cmd.in_ready && i_rst_n;
    assign accept = i_req.valid && i_req.ready;

    // request latch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_req.op;
            r_t0 <= i_req.start_ts;
            r_t1 <= i_req.stop_time;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end
    end

    assign n_sgn = signed'({1'b0, r_count});
    assign n_m1  = n_sgn - ONE;

    // key and probed field, start side for floor, stop side for ceiling
    assign key   = i_cmd.ceil_sel ? r_t1 : r_t0;
    assign probe = i_cmd.ceil_sel ? ram_rdata[TW-1:0] : ram_rdata[2*TW-1:TW];

    // next search bounds
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        case (i_cmd.bnd_op)
            trfis_pkg::BND_INIT: begin
                n_lo = '0;
                n_hi = n_m1;
            end
            trfis_pkg::BND_STEP: begin
                if (key < probe) begin
                    n_hi = r_mid - ONE;
                end else if (key > probe) begin
                    n_lo = r_mid + ONE;
                end
            end
            default: begin
            end
        endcase
    end

    // midpoint of the next bounds, both non-negative while probing
    assign mid_sum  = n_lo + n_hi;
    assign mid_calc = signed'({1'b0, mid_sum[LW-1:1]});

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_cmd.addr_sel == trfis_pkg::ADDR_MID) begin
            r_mid <= mid_calc;
        end
    end

    // table address
    always_comb begin
        unique case (i_cmd.addr_sel)
            trfis_pkg::ADDR_ZERO: ram_addr = '0;
            trfis_pkg::ADDR_LAST: ram_addr = n_m1[IW-1:0];
            trfis_pkg::ADDR_MID:  ram_addr = mid_calc[IW-1:0];
            trfis_pkg::ADDR_LO:   ram_addr = n_lo[IW-1:0];
            default:              ram_addr = '0;
        endcase
        if (i_cmd.wr_en) begin
            ram_addr = r_count[IW-1:0];
        end
    end

    trfis_ram #(
        .WIDTH(2 * TW),
        .DEPTH(MAX_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_addr (ram_addr),
        .i_wdata({r_t0, r_t1}),
        .o_rdata(ram_rdata)
    );

    // search result value
    always_comb begin
        unique case (i_cmd.res_sel)
            trfis_pkg::RES_NEG1: res_val = '1;
            trfis_pkg::RES_LAST: res_val = n_m1;
            trfis_pkg::RES_MID:  res_val = r_mid;
            trfis_pkg::RES_LO:   res_val = n_lo;
            trfis_pkg::RES_LOM1: res_val = n_lo - ONE;
            trfis_pkg::RES_LOP1: res_val = n_lo + ONE;
            default:             res_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_wr_a) begin
            r_a <= res_val;
        end
        if (i_cmd.res_wr_b) begin
            r_b <= res_val;
        end
    end

    // working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
            r_first  <= i_cmd.idx_en ? XW'(unsigned'(r_a)) : '0;
            r_last   <= i_cmd.idx_en ? XW'(unsigned'(r_b)) : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_first  <= r_first;
            r_out_last   <= r_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.first_index = r_out_first;
    assign o_rsp.last_index  = r_out_last;

    // status toward the controller
    always_comb begin
        o_stat            = '0;
        o_stat.in_valid   = i_req.valid;
        o_stat.op         = r_op;
        o_stat.bad_append = r_t0 >= r_t1;
        o_stat.bad_query  = r_t1 <= r_t0;
        o_stat.full       = r_count == CW'(MAX_ENTRIES);
        o_stat.empty      = r_count == '0;
        o_stat.key_lt     = key < probe;
        o_stat.key_gt     = key > probe;
        o_stat.more       = n_lo <= n_hi;
        o_stat.lo_in      = n_lo < n_sgn;
        o_stat.cover_ok   = (r_a >= 0) && (r_b >= 0) && (r_a <= n_m1)
                            && (r_b <= n_m1) && (r_a <= r_b);
        o_stat.out_free   = !r_out_valid || o_rsp.ready;
    end

endmodule

[design/trfis_ctrl.sv]
// controller: sequences decode, floor search, ceiling search and result load
// depends on trfis_pkg

module trfis_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trfis_pkg::t_dp_stat i_stat,
    output trfis_pkg::t_dp_cmd  o_cmd
);

    trfis_pkg::t_state r_state, n_state;
    logic              found;

    assign found = !i_stat.key_lt && !i_stat.key_gt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trfis_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trfis_pkg::S_IDLE: begin
                if (i_stat.in_valid) n_state = trfis_pkg::S_DECODE;
            end
            trfis_pkg::S_DECODE: begin
                if (i_stat.op == trfis_pkg::OP_QUERY && !i_stat.bad_query
                    && !i_stat.empty) begin
                    n_state = trfis_pkg::S_F_FIRST;
                end else begin
                    n_state = trfis_pkg::S_DONE;
                end
            end
            trfis_pkg::S_F_FIRST: begin
                n_state = i_stat.key_lt ? trfis_pkg::S_C_LAST : trfis_pkg::S_F_PROBE;
            end
            trfis_pkg::S_F_PROBE: begin
                if (found) n_state = trfis_pkg::S_C_LAST;
                else if (i_stat.more) n_state = trfis_pkg::S_F_PROBE;
                else if (i_stat.lo_in) n_state = trfis_pkg::S_F_TAIL;
                else n_state = trfis_pkg::S_C_LAST;
            end
            trfis_pkg::S_F_TAIL: n_state = trfis_pkg::S_C_LAST;
            trfis_pkg::S_C_LAST: begin
                n_state = i_stat.key_gt ? trfis_pkg::S_CHECK : trfis_pkg::S_C_PROBE;
            end
            trfis_pkg::S_C_PROBE: begin
                if (found) n_state = trfis_pkg::S_CHECK;
                else if (i_stat.more) n_state = trfis_pkg::S_C_PROBE;
                else if (i_stat.lo_in) n_state = trfis_pkg::S_C_TAIL;
                else n_state = trfis_pkg::S_CHECK;
            end
            trfis_pkg::S_C_TAIL: n_state = trfis_pkg::S_CHECK;
            trfis_pkg::S_CHECK:  n_state = trfis_pkg::S_DONE;
            trfis_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = trfis_pkg::S_IDLE;
            end
            default: n_state = trfis_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            trfis_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            trfis_pkg::S_DECODE: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status     = trfis_pkg::STS_BAD;
                unique case (i_stat.op)
                    trfis_pkg::OP_APPEND: begin
                        if (i_stat.bad_append) begin
                            o_cmd.status = trfis_pkg::STS_BAD;
                        end else if (i_stat.full) begin
                            o_cmd.status = trfis_pkg::STS_FULL;
                        end else begin
                            o_cmd.status  = trfis_pkg::STS_OK;
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    trfis_pkg::OP_CLEAR: begin
                        o_cmd.status  = trfis_pkg::STS_OK;
                        o_cmd.cnt_clr = 1'b1;
                    end
                    trfis_pkg::OP_QUERY: begin
                        if (i_stat.bad_query) begin
                            o_cmd.status = trfis_pkg::STS_BAD;
                        end else if (i_stat.empty) begin
                            o_cmd.status = trfis_pkg::STS_EMPTY;
                        end else begin
                            o_cmd.set_status = 1'b0;
                            o_cmd.addr_sel   = trfis_pkg::ADDR_ZERO;
                        end
                    end
                    default: begin
                        o_cmd.status = trfis_pkg::STS_BAD;
                    end
                endcase
            end
            // first start time decides whether any entry can be the floor
            trfis_pkg::S_F_FIRST: begin
                if (i_stat.key_lt) begin
                    o_cmd.res_sel  = trfis_pkg::RES_NEG1;
                    o_cmd.res_wr_a = 1'b1;
                    o_cmd.addr_sel = trfis_pkg::ADDR_LAST;
                end else begin
                    o_cmd.bnd_op   = trfis_pkg::BND_INIT;
                    o_cmd.addr_sel = trfis_pkg::ADDR_MID;
                end
            end
            trfis_pkg::S_F_PROBE: begin
                o_cmd.bnd_op = trfis_pkg::BND_STEP;
                if (found) begin
                    o_cmd.res_sel  = trfis_pkg::RES_MID;
                    o_cmd.res_wr_a = 1'b1;
                    o_cmd.addr_sel = trfis_pkg::ADDR_LAST;
                end else if (i_stat.more) begin
                    o_cmd.addr_sel = trfis_pkg::ADDR_MID;
                end else if (i_stat.lo_in) begin
                    o_cmd.addr_sel = trfis_pkg::ADDR_LO;
                end else begin
                    o_cmd.res_sel  = trfis_pkg::RES_LOM1;
                    o_cmd.res_wr_a = 1'b1;
                    o_cmd.addr_sel = trfis_pkg::ADDR_LAST;
                end
            end
            trfis_pkg::S_F_TAIL: begin
                o_cmd.res_sel  = i_stat.key_gt ? trfis_pkg::RES_LO : trfis_pkg::RES_LOM1;
                o_cmd.res_wr_a = 1'b1;
                o_cmd.addr_sel = trfis_pkg::ADDR_LAST;
            end
            // last stop time decides whether the ceiling falls past the table
            trfis_pkg::S_C_LAST: begin
                o_cmd.ceil_sel = 1'b1;
                if (i_stat.key_gt) begin
                    o_cmd.res_sel  = trfis_pkg::RES_LAST;
                    o_cmd.res_wr_b = 1'b1;
                end else begin
                    o_cmd.bnd_op   = trfis_pkg::BND_INIT;
                    o_cmd.addr_sel = trfis_pkg::ADDR_MID;
                end
            end
            trfis_pkg::S_C_PROBE: begin
                o_cmd.ceil_sel = 1'b1;
                o_cmd.bnd_op   = trfis_pkg::BND_STEP;
                if (found) begin
                    o_cmd.res_sel  = trfis_pkg::RES_MID;
                    o_cmd.res_wr_b = 1'b1;
                end else if (i_stat.more) begin
                    o_cmd.addr_sel = trfis_pkg::ADDR_MID;
                end else if (i_stat.lo_in) begin
                    o_cmd.addr_sel = trfis_pkg::ADDR_LO;
                end else begin
                    o_cmd.res_sel  = trfis_pkg::RES_LAST;
                    o_cmd.res_wr_b = 1'b1;
                end
            end
            trfis_pkg::S_C_TAIL: begin
                o_cmd.ceil_sel = 1'b1;
                o_cmd.res_sel  = i_stat.key_lt ? trfis_pkg::RES_LO : trfis_pkg::RES_LOP1;
                o_cmd.res_wr_b = 1'b1;
            end
            trfis_pkg::S_CHECK: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status     = i_stat.cover_ok ? trfis_pkg::STS_OK
                                                   : trfis_pkg::STS_NOCOVER;
                o_cmd.idx_en     = i_stat.cover_ok;
            end
            trfis_pkg::S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[design/time_range_file_index_search.sv]
// interval table with floor/ceiling range search, one request at a time
// append, clear and rejected requests: status set in decode, loaded out in done
// query: floor then ceiling binary search, each at most log2(entries)+1 probes,
// then a cover check; each probe waits one registered table read
// next request is taken the cycle after the result moves into the output register
// reset (sync, active low) empties the table; entry contents stay undefined, no sweep

module time_range_file_index_search #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trfis_in_if.sink    i_req,
    trfis_out_if.source o_rsp
);

    trfis_pkg::t_dp_cmd  cmd;
    trfis_pkg::t_dp_stat stat;

    // sequencer
    trfis_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    // table, search registers and output register
    trfis_dp #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .o_rsp  (o_rsp),
        .i_cmd  (cmd),
        .o_stat (stat)
    );

endmodule
